### design/ptrf_pkg.sv
// Shared types, constants and helpers of the printable text run finder.
package ptrf_pkg;

  localparam int unsigned LEN_W   = 13;  // reported run length and minimum
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned OFS_W   = 20;  // holds any start offset in range
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd1;

  localparam logic [LEN_W-1:0] MIN_LEN_RST = 13'd4;

  // Run encodings
  localparam logic ENC_ASCII = 1'b0;
  localparam logic ENC_UTF16 = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [OFS_W-1:0] start;
    logic [LEN_W-1:0] len;
  } run_rec_t;

  // Everything one byte produced; the ASCII run goes out first.
  typedef struct packed {
    run_rec_t ascii;
    run_rec_t wide;
  } run_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_printable(input logic [7:0] b);
    return b inside {[PRINT_LO:PRINT_HI]};
  endfunction

endpackage

### design/ptrf_front.sv
// Front end: tracks the ASCII and UTF-16LE runs and records finished runs.
module ptrf_front #(
  parameter int unsigned MAX_BYTES = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_final_byte,
  input  logic [ptrf_pkg::LEN_W-1:0] min_len,
  input  ptrf_pkg::q_stat_t         q_stat,
  output logic                      push,
  output ptrf_pkg::run_pair_t       entry
);
  import ptrf_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_BYTES + 1);
  localparam int unsigned SW   = $clog2(MAX_BYTES);
  localparam int unsigned CMPW = (CW > LEN_W) ? CW : LEN_W;

  logic [CW-1:0] ofs_r, ofs_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic          n_act_r, n_act_nxt;
  logic [SW-1:0] n_start_r, n_start_nxt;
  logic [CW-1:0] n_cnt_r, n_cnt_nxt;
  logic          w_act_r, w_act_nxt;
  logic          w_phase_r, w_phase_nxt;
  logic [SW-1:0] w_start_r, w_start_nxt;
  logic [CW-1:0] w_cnt_r, w_cnt_nxt;

  logic            accept, cur_pr, pair_ok, n_close, w_close;
  logic [CW-1:0]   pos_m1;
  logic [CMPW-1:0] least;
  // updated tracker values before the final-byte clear
  logic            n_act_u, w_act_u, w_phase_u;
  logic [SW-1:0]   n_start_u, w_start_u;
  logic [CW-1:0]   n_cnt_u, w_cnt_u;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v < CW'(MAX_BYTES)) ? v + CW'(1) : CW'(MAX_BYTES);
  endfunction

  function automatic logic [SW-1:0] cap_start(input logic [CW-1:0] p);
    return (p < CW'(MAX_BYTES - 1)) ? SW'(p) : SW'(MAX_BYTES - 1);
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign cur_pr   = is_printable(in_data_byte);
  assign pair_ok  = is_printable(prev_r) && (in_data_byte == 8'h00);
  assign pos_m1   = (ofs_r != '0) ? ofs_r - CW'(1) : '0;
  assign least    = (min_len == '0) ? CMPW'(1) : CMPW'(min_len);

  always_comb begin
    // ASCII tracker
    n_act_u   = n_act_r;
    n_start_u = n_start_r;
    n_cnt_u   = n_cnt_r;
    n_close   = 1'b0;
    if (cur_pr) begin
      if (n_act_r) begin
        n_cnt_u = sat_inc(n_cnt_r);
      end else begin
        n_act_u   = 1'b1;
        n_start_u = cap_start(ofs_r);
        n_cnt_u   = CW'(1);
      end
    end else if (n_act_r) begin
      n_close = 1'b1;
      n_act_u = 1'b0;
    end
    if (in_final_byte && n_act_u) begin
      n_close = 1'b1;
      n_act_u = 1'b0;
    end

    // UTF-16LE tracker: pair scan, every offset while idle
    w_act_u   = w_act_r;
    w_phase_u = w_phase_r;
    w_start_u = w_start_r;
    w_cnt_u   = w_cnt_r;
    w_close   = 1'b0;
    if (w_act_r) begin
      if (!w_phase_r) begin
        w_phase_u = 1'b1;
      end else if (pair_ok) begin
        w_cnt_u   = sat_inc(w_cnt_r);
        w_phase_u = 1'b0;
      end else begin
        w_close   = 1'b1;
        w_act_u   = 1'b0;
        w_phase_u = 1'b0;
      end
    end else if (pair_ok) begin
      w_act_u   = 1'b1;
      w_start_u = cap_start(pos_m1);
      w_cnt_u   = CW'(1);
      w_phase_u = 1'b0;
    end
    if (in_final_byte && w_act_u) begin
      w_close   = 1'b1;
      w_act_u   = 1'b0;
      w_phase_u = 1'b0;
    end

    entry.ascii.valid = n_close && (CMPW'(n_cnt_u) >= least);
    entry.ascii.start = OFS_W'(n_start_u);
    entry.ascii.len   = LEN_W'(n_cnt_u);
    entry.wide.valid  = w_close && (CMPW'(w_cnt_u) >= least);
    entry.wide.start  = OFS_W'(w_start_u);
    entry.wide.len    = LEN_W'(w_cnt_u);

    if (in_final_byte) begin
      ofs_nxt     = '0;
      prev_nxt    = '0;
      n_act_nxt   = 1'b0;
      n_start_nxt = '0;
      n_cnt_nxt   = '0;
      w_act_nxt   = 1'b0;
      w_phase_nxt = 1'b0;
      w_start_nxt = '0;
      w_cnt_nxt   = '0;
    end else begin
      ofs_nxt     = sat_inc(ofs_r);
      prev_nxt    = in_data_byte;
      n_act_nxt   = n_act_u;
      n_start_nxt = n_start_u;
      n_cnt_nxt   = n_cnt_u;
      w_act_nxt   = w_act_u;
      w_phase_nxt = w_phase_u;
      w_start_nxt = w_start_u;
      w_cnt_nxt   = w_cnt_u;
    end
  end

  assign push = accept && (entry.ascii.valid || entry.wide.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r     <= '0;
      prev_r    <= '0;
      n_act_r   <= 1'b0;
      n_start_r <= '0;
      n_cnt_r   <= '0;
      w_act_r   <= 1'b0;
      w_phase_r <= 1'b0;
      w_start_r <= '0;
      w_cnt_r   <= '0;
    end else if (accept) begin
      ofs_r     <= ofs_nxt;
      prev_r    <= prev_nxt;
      n_act_r   <= n_act_nxt;
      n_start_r <= n_start_nxt;
      n_cnt_r   <= n_cnt_nxt;
      w_act_r   <= w_act_nxt;
      w_phase_r <= w_phase_nxt;
      w_start_r <= w_start_nxt;
      w_cnt_r   <= w_cnt_nxt;
    end
  end

endmodule

### design/ptrf_queue.sv
// Small register FIFO of finished-run records between front and back.
module ptrf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ptrf_pkg::run_pair_t push_data,
  input  logic                pop,
  output ptrf_pkg::run_pair_t head,
  output ptrf_pkg::q_stat_t   stat
);
  import ptrf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  run_pair_t     mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == NW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

### design/ptrf_back.sv
// Back end: splits queued records into run transactions and holds the output.
module ptrf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptrf_pkg::run_pair_t         head,
  input  ptrf_pkg::q_stat_t           q_stat,
  output logic                        pop,
  input  logic [ptrf_pkg::ADDR_W-1:0] base_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_run_encoding,
  output logic [ptrf_pkg::ADDR_W-1:0] out_run_address,
  output logic [ptrf_pkg::LEN_W-1:0]  out_run_length,
  output logic                        out_last_of_item
);
  import ptrf_pkg::*;

  logic              valid_r, valid_nxt;
  logic              phase_r, phase_nxt;   // ASCII half of head already sent
  logic              enc_r, last_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic              slot_free, load, sel_wide, last;
  run_rec_t          rec;

  assign slot_free = !valid_r || !out_stall;
  assign load      = slot_free && !q_stat.empty;
  assign sel_wide  = !head.ascii.valid || phase_r;
  assign rec       = sel_wide ? head.wide : head.ascii;
  assign last      = sel_wide || !head.wide.valid;
  assign pop       = load && last;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = !last;
    end else if (slot_free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      enc_r  <= sel_wide ? ENC_UTF16 : ENC_ASCII;
      addr_r <= base_addr + ADDR_W'(rec.start);
      len_r  <= rec.len;
      last_r <= last;
    end
  end

  assign out_valid        = valid_r;
  assign out_run_encoding = enc_r;
  assign out_run_address  = addr_r;
  assign out_run_length   = len_r;
  assign out_last_of_item = last_r;

endmodule

### design/printable_text_run_finder.sv
// Top level of the printable text run finder: config registers and wiring.
//
// Usage:
//   Input channel (in_valid / in_stall): one snapshot byte per transaction,
//   in_final_byte set on the last byte. A byte is taken every cycle unless
//   the run queue is full; a full queue stalls every byte, run or not.
//   Output channel (out_valid / out_stall): one reported run per
//   transaction: encoding, start address, length in characters, and
//   out_last_of_item on the last run caused by one input byte. A byte can
//   end an ASCII and a UTF-16LE run at once; the ASCII run comes first.
//   A run goes through the run queue and the output register to out_valid.
//   Throughput: one byte per cycle in while the queue has room, one run per
//   cycle out while out_stall is low; the output register and the run
//   queue (QUEUE_DEPTH records) decouple the sides, so a stalled receiver
//   only backs up the input once the queue fills.
//   Config (cfg_we / cfg_index / cfg_wdata): min_run_length and
//   base_address, written while the block is idle; other indexes ignored.
//   Reset (rst_n, synchronous): clears trackers, queue and output; the
//   minimum returns to 4 and the base address to 0. The final byte of a
//   snapshot clears the trackers but leaves configuration alone.
module printable_text_run_finder #(
  parameter int unsigned MAX_BYTES   = 4096,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_final_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_run_encoding,
  output logic [ptrf_pkg::ADDR_W-1:0]     out_run_address,
  output logic [ptrf_pkg::LEN_W-1:0]      out_run_length,
  output logic                            out_last_of_item,
  input  logic                            cfg_we,
  input  logic [ptrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptrf_pkg::ADDR_W-1:0]     cfg_wdata
);
  import ptrf_pkg::*;

  logic [LEN_W-1:0]  min_len_r;
  logic [ADDR_W-1:0] base_r;

  run_pair_t entry, head;
  q_stat_t   q_stat;
  logic      push, pop;

  // Config writes; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      base_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LEN: min_len_r <= cfg_wdata[LEN_W-1:0];
        REG_BASE:    base_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: both trackers advance once per accepted byte
  ptrf_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .min_len       (min_len_r),
    .q_stat        (q_stat),
    .push          (push),
    .entry         (entry)
  );

  // Records of finished runs, one per byte that ended at least one run of reportable length
  ptrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back: one run per cycle into the output register while out_stall allows, address added here
  ptrf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .base_addr        (base_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_run_encoding (out_run_encoding),
    .out_run_address  (out_run_address),
    .out_run_length   (out_run_length),
    .out_last_of_item (out_last_of_item)
  );

endmodule

### design/ptrf_checker.sv
// Port-level assertions for the printable text run finder, bound to the top.
module ptrf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_run_encoding,
  input logic [ptrf_pkg::ADDR_W-1:0] out_run_address,
  input logic [ptrf_pkg::LEN_W-1:0]  out_run_length,
  input logic                        out_last_of_item
);
  import ptrf_pkg::*;

  // A stalled run holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_run_address)
      && $stable(out_run_length) && $stable(out_run_encoding)
      && $stable(out_last_of_item))
    else $error("stalled run changed");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reported runs are never empty
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != '0)
    else $error("zero-length run reported");

  // First of two runs from one byte is the ASCII run; unless stalled, its partner follows at once
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_item && !out_stall |=>
      out_valid && out_run_encoding == ENC_UTF16 && out_last_of_item)
    else $error("second run of a byte missing or out of order");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_item |-> out_run_encoding == ENC_ASCII)
    else $error("non-final run is not ASCII");

endmodule

bind printable_text_run_finder ptrf_checker u_ptrf_checker (.*);
